### src/ple_pkg.sv
// shared types and codes for the positional list engine
package ple_pkg;

  localparam int unsigned DEF_CAPACITY = 64;
  localparam int unsigned DATA_W       = 32;
  // wide enough for any position or count up to the largest supported capacity
  localparam int unsigned IDX_W        = 13;

  localparam logic [2:0] FUNC_INSERT = 3'd0;
  localparam logic [2:0] FUNC_DELETE = 3'd1;
  localparam logic [2:0] FUNC_SET    = 3'd2;
  localparam logic [2:0] FUNC_GET    = 3'd3;
  localparam logic [2:0] FUNC_LOCATE = 3'd4;
  localparam logic [2:0] FUNC_CLEAR  = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_LOAD,
    CMD_SHIFT_UP,
    CMD_SHIFT_DOWN
  } cell_cmd_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic              capture;
    cell_cmd_t         cmd;
    logic [IDX_W-1:0]  lo;
    logic [IDX_W-1:0]  hi;
    logic [IDX_W-1:0]  limit;
    logic [DATA_W-1:0] value;
  } ple_ctrl_t;

endpackage

### src/ple_cell.sv
// one list slot: holds an element, shifts to/from its neighbors, flags match and select
module ple_cell import ple_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  logic              clk,
  input  ple_ctrl_t         ctrl,
  input  logic [DATA_W-1:0] left_data,
  input  logic [DATA_W-1:0] right_data,
  output logic [DATA_W-1:0] data,
  output logic              hit,
  output logic              sel
);

  localparam logic [IDX_W-1:0] MY = IDX_W'(IDX);

  always_ff @(posedge clk) begin
    case (ctrl.cmd)
      CMD_LOAD: begin
        if (MY == ctrl.lo) data <= ctrl.value;
      end
      CMD_SHIFT_UP: begin
        if (MY == ctrl.lo) begin
          data <= ctrl.value;
        end else if (MY > ctrl.lo && MY <= ctrl.hi) begin
          data <= left_data;
        end
      end
      CMD_SHIFT_DOWN: begin
        if (MY >= ctrl.lo && MY < ctrl.hi) data <= right_data;
      end
      default: begin
      end
    endcase
    // flags see the contents before this request's update
    if (ctrl.capture) begin
      hit <= (data == ctrl.value) && (MY < ctrl.limit);
      sel <= (MY == ctrl.lo);
    end
  end

endmodule

### src/ple_reduce.sv
// collects the cell flags into the read word and the first matching position
module ple_reduce import ple_pkg::*; #(
  parameter int unsigned CAPACITY = DEF_CAPACITY,
  parameter int unsigned CW       = $clog2(CAPACITY + 1)
) (
  input  logic [CAPACITY-1:0] hit,
  input  logic [CAPACITY-1:0] sel,
  input  logic [DATA_W-1:0]   elems [CAPACITY],
  output logic [DATA_W-1:0]   rdata,
  output logic [CW-1:0]       found
);

  logic [CAPACITY-1:0] first_hit;

  always_comb begin
    // isolate lowest set flag
    first_hit = hit & (~hit + 1'b1);
    rdata = '0;
    found = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (sel[i]) rdata = rdata | elems[i];
      if (first_hit[i]) found = found | CW'(i + 1);
    end
  end

endmodule

### src/positional_list_engine_core.sv
// positional list engine: chain of element cells with request decode and result register
// the cell chain updates and the cell flags are captured when a request is accepted;
// the flags then reduce and the output register loads when free (rsp_valid low or rsp_ready high)
// req_ready stays low until that load; a new request is then taken while the result still waits
// reset clears the list count, busy flag and result valid; element cells are not reset
module positional_list_engine_core import ple_pkg::*; #(
  parameter int unsigned CAPACITY = DEF_CAPACITY
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic [2:0]         func,
  input  logic [6:0]         position,
  input  logic signed [31:0] value,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output logic [1:0]         status,
  output logic signed [31:0] read_data,
  output logic [6:0]         found_at,
  output logic [6:0]         length
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic                busy;
  logic [1:0]          status_q;
  logic [1:0]          status_next;
  logic                get_q;
  logic                get_next;
  logic                find_q;
  logic                find_next;
  logic                accept;
  logic                load;
  logic [IDX_W-1:0]    pos_x;
  logic [IDX_W-1:0]    cnt_x;
  logic                in_list;
  ple_ctrl_t           ctrl;
  logic [DATA_W-1:0]   elems [CAPACITY];
  logic [CAPACITY-1:0] hit;
  logic [CAPACITY-1:0] sel;
  logic [DATA_W-1:0]   rdata;
  logic [CW-1:0]       found;

  assign req_ready = !busy;
  assign accept    = req_valid && req_ready;
  assign load      = busy && (!rsp_valid || rsp_ready);

  assign pos_x   = IDX_W'(position);
  assign cnt_x   = IDX_W'(count);
  assign in_list = (pos_x != '0) && (pos_x <= cnt_x);

  always_comb begin
    ctrl.capture = accept;
    ctrl.cmd     = CMD_HOLD;
    ctrl.lo      = pos_x - 1'b1;
    ctrl.hi      = cnt_x;
    ctrl.limit   = cnt_x;
    ctrl.value   = value;
    status_next  = ST_OK;
    count_next   = count;
    get_next     = 1'b0;
    find_next    = 1'b0;
    if (accept) begin
      case (func)
        FUNC_INSERT: begin
          if (pos_x == '0 || pos_x > cnt_x + 1'b1) begin
            status_next = ST_RANGE;
          end else if (count == CW'(CAPACITY)) begin
            status_next = ST_FULL;
          end else begin
            ctrl.cmd   = CMD_SHIFT_UP;
            count_next = count + 1'b1;
          end
        end
        FUNC_DELETE: begin
          if (!in_list) begin
            status_next = ST_RANGE;
          end else begin
            ctrl.cmd   = CMD_SHIFT_DOWN;
            ctrl.hi    = cnt_x - 1'b1;
            count_next = count - 1'b1;
          end
        end
        FUNC_SET: begin
          if (!in_list) status_next = ST_RANGE;
          else ctrl.cmd = CMD_LOAD;
        end
        FUNC_GET: begin
          if (!in_list) status_next = ST_RANGE;
          else get_next = 1'b1;
        end
        FUNC_LOCATE: begin
          find_next = 1'b1;
        end
        FUNC_CLEAR: begin
          count_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_W-1:0] left_in;
    logic [DATA_W-1:0] right_in;
    if (g == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_mid_l
      assign left_in = elems[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_mid_r
      assign right_in = elems[g+1];
    end
    ple_cell #(.IDX(g)) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .left_data  (left_in),
      .right_data (right_in),
      .data       (elems[g]),
      .hit        (hit[g]),
      .sel        (sel[g])
    );
  end

  ple_reduce #(.CAPACITY(CAPACITY), .CW(CW)) u_reduce (
    .hit   (hit),
    .sel   (sel),
    .elems (elems),
    .rdata (rdata),
    .found (found)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      busy      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        busy     <= 1'b1;
        status_q <= status_next;
        get_q    <= get_next;
        find_q   <= find_next;
      end else if (load) begin
        busy <= 1'b0;
      end
      if (load) begin
        rsp_valid <= 1'b1;
        status    <= status_q;
        read_data <= get_q ? rdata : '0;
        found_at  <= find_q ? 7'(found) : 7'd0;
        length    <= 7'(count);
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("list length beyond capacity");

  a_rsp_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(busy))
    else $error("result raised without a request in flight");

  a_full_only_at_cap: assert property (@(posedge clk) disable iff (rst)
    (load && status_q == ST_FULL) |-> count == CW'(CAPACITY))
    else $error("full status with room left");

  a_len_tracks: assert property (@(posedge clk) disable iff (rst)
    load |=> length == 7'(count))
    else $error("reported length differs from stored count");

endmodule
